// ===== rtl/bit_matrix_transpose_core_assert.svh =====
// Assertion macros shared by the bit matrix transpose RTL.
`ifndef BIT_MATRIX_TRANSPOSE_CORE_ASSERT_SVH
`define BIT_MATRIX_TRANSPOSE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked on every rising edge of clk, off while rst_n is low.
`define BMT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bit matrix transpose assertion failed");
// Condition that must never hold outside reset.
`define BMT_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bit matrix transpose forbidden condition");
`else
`define BMT_ASSERT(label, prop)
`define BMT_ASSERT_NEVER(label, cond)
`endif

`endif

// ===== rtl/bmt_pkg.sv =====
// Types and constants for the bit matrix transpose core.
package bmt_pkg;

    localparam int HALF_W    = 64;
    localparam int ROW_MAX_W = 2 * HALF_W;
    localparam int IDX_MAX_W = 7;
    localparam int SIZE_W    = 3;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_MIN   = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 3'd7;

    typedef struct packed {
        logic              mode;
        logic [HALF_W-1:0] row_low;
        logic [HALF_W-1:0] row_high;
    } in_t;

    typedef struct packed {
        logic [HALF_W-1:0] column_low;
        logic [HALF_W-1:0] column_high;
        logic              last_column;
    } out_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                 wr_en;
        logic [IDX_MAX_W-1:0] wr_sel;
        logic [ROW_MAX_W-1:0] wr_row;
        logic                 rd_en;
        logic [IDX_MAX_W-1:0] rd_sel;
        logic                 rd_last;
        logic [IDX_MAX_W-1:0] n_mask;
    } cmd_t;

endpackage

// ===== rtl/bit_matrix_transpose_core.sv =====
// Top level of the streaming square bit matrix transpose core.
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+----------------------------------
//  config   | cfg_wr_en, cfg_wr_data           | size_log2 (side = 2**size_log2)
//  in       | in_valid, in_ready, in_data      | mode, row_low, row_high
//  out      | out_valid, out_ready, out_data   | column_low, column_high, last_column
//
// One transaction per cycle on the in channel unless out stalls. A row write
// is stored at the accepting edge; a column read is sampled by every cell at
// the accepting edge and shows on out the next cycle in per-cell bit registers.
// Reset (async, rst_n low) zeroes all stored rows and both counters and sets
// the side to the largest supported size. While a column waits on out_ready,
// in_ready stays high only if the waiting column is taken in the same cycle.
`include "bit_matrix_transpose_core_assert.svh"

module bit_matrix_transpose_core #(
    parameter int MAX_SIDE = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bmt_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  bmt_pkg::in_t               in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bmt_pkg::out_t              out_data
);
    import bmt_pkg::*;

    // Largest power of two not above MAX_SIDE, kept within 8..128.
    localparam int FLOOR_LOG2 = $clog2(MAX_SIDE + 1) - 1;
    localparam int CAP_LOG2   = (FLOOR_LOG2 < 3) ? 3 : ((FLOOR_LOG2 > 7) ? 7 : FLOOR_LOG2);
    localparam int SIDE_CAP   = 1 << CAP_LOG2;

    cmd_t                 cmd;
    logic                 accept;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 last_reg;
    logic                 last_next;
    logic [ROW_MAX_W-1:0] column;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    bmt_ctrl #(
        .CAP_LOG2 (CAP_LOG2)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd)
    );

    // Chain of row cells; cell i supplies bit i of every column read.
    for (genvar i = 0; i < ROW_MAX_W; i++)
    begin : g_cell
        if (i < SIDE_CAP)
        begin : g_row
            bmt_cell #(
                .INDEX (i),
                .ROW_W (SIDE_CAP),
                .SEL_W (CAP_LOG2)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .col_bit (column[i])
            );
        end
        else
        begin : g_pad
            assign column[i] = 1'b0;
        end
    end

    // Output slot: loads on a read transaction, drains on out_ready.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        if (cmd.rd_en)
        begin
            out_valid_next = 1'b1;
            last_next      = cmd.rd_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
    end

    assign out_valid            = out_valid_reg;
    assign out_data.column_low  = column[HALF_W-1:0];
    assign out_data.column_high = column[ROW_MAX_W-1:HALF_W];
    assign out_data.last_column = last_reg;

    // A read always yields a column next cycle; a write never creates one.
    `BMT_ASSERT(a_rd_result, cmd.rd_en |=> out_valid_reg)
    `BMT_ASSERT(a_wr_silent, (cmd.wr_en && !out_valid_reg) |=> !out_valid_reg)
    `BMT_ASSERT(a_no_overrun, (out_valid_reg && !out_ready) |-> !cmd.rd_en)

endmodule

// ===== rtl/bmt_cell.sv =====
// One row cell: holds a stored row and taps one column bit on a read.
module bmt_cell #(
    parameter int INDEX = 0,
    parameter int ROW_W = 128,
    parameter int SEL_W = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bmt_pkg::cmd_t cmd,
    output logic          col_bit
);
    import bmt_pkg::*;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             bit_reg;
    logic             bit_next;
    logic             active;

    // Rows at or above the current side contribute zero.
    assign active = ((IDX_MAX_W'(INDEX) & ~cmd.n_mask) == '0);

    always_comb
    begin
        row_next = row_reg;
        if (cmd.wr_en && (cmd.wr_sel[SEL_W-1:0] == SEL_W'(INDEX)))
        begin
            row_next = cmd.wr_row[ROW_W-1:0];
        end
    end

    always_comb
    begin
        bit_next = bit_reg;
        if (cmd.rd_en)
        begin
            bit_next = row_reg[cmd.rd_sel[SEL_W-1:0]] & active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign col_bit = bit_reg;

endmodule

// ===== rtl/bmt_ctrl.sv =====
// Size register, row and column counters, and the command broadcast to the cells.
`include "bit_matrix_transpose_core_assert.svh"

module bmt_ctrl #(
    parameter int CAP_LOG2 = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  bmt_pkg::in_t                 in_data,
    input  logic                         cfg_wr_en,
    input  logic [bmt_pkg::SIZE_W-1:0]   cfg_wr_data,
    output bmt_pkg::cmd_t                cmd
);
    import bmt_pkg::*;

    localparam int                CNT_W    = CAP_LOG2;
    localparam logic [SIZE_W-1:0] CAP_CODE = SIZE_W'(CAP_LOG2);

    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    size_next;
    logic [CNT_W-1:0]     row_cnt_reg;
    logic [CNT_W-1:0]     row_cnt_next;
    logic [CNT_W-1:0]     col_cnt_reg;
    logic [CNT_W-1:0]     col_cnt_next;
    logic [SIZE_W-1:0]    side_log2;
    logic [7:0]           side_mask8;
    logic [IDX_MAX_W-1:0] n_mask;
    logic [CNT_W-1:0]     cnt_mask;
    logic [CNT_W-1:0]     row_sel;
    logic [CNT_W-1:0]     col_sel;
    logic [ROW_MAX_W-1:0] row_mask;
    logic                 wr_en;
    logic                 rd_en;

    // Clamp the programmed size_log2 into [3, CAP_CODE], so the side lies in [8, cap].
    always_comb
    begin
        if (size_reg < SIZE_LOG2_MIN)
        begin
            side_log2 = SIZE_LOG2_MIN;
        end
        else if (size_reg > CAP_CODE)
        begin
            side_log2 = CAP_CODE;
        end
        else
        begin
            side_log2 = size_reg;
        end
    end

    assign side_mask8 = (8'd1 << side_log2) - 8'd1;
    assign n_mask     = side_mask8[IDX_MAX_W-1:0];
    assign cnt_mask   = n_mask[CNT_W-1:0];
    assign row_sel    = row_cnt_reg & cnt_mask;
    assign col_sel    = col_cnt_reg & cnt_mask;

    always_comb
    begin
        for (int k = 0; k < ROW_MAX_W; k++)
        begin
            row_mask[k] = ((8'(k) >> side_log2) == 8'd0);
        end
    end

    assign wr_en = accept && (in_data.mode == MODE_WRITE);
    assign rd_en = accept && (in_data.mode == MODE_READ);

    always_comb
    begin
        cmd.wr_en   = wr_en;
        cmd.wr_sel  = IDX_MAX_W'(row_sel);
        cmd.wr_row  = {in_data.row_high, in_data.row_low} & row_mask;
        cmd.rd_en   = rd_en;
        cmd.rd_sel  = IDX_MAX_W'(col_sel);
        cmd.rd_last = (col_sel == cnt_mask);
        cmd.n_mask  = n_mask;
    end

    assign size_next    = cfg_wr_en ? cfg_wr_data : size_reg;
    assign row_cnt_next = wr_en ? ((row_sel + CNT_W'(1)) & cnt_mask) : row_cnt_reg;
    assign col_cnt_next = rd_en ? ((col_sel + CNT_W'(1)) & cnt_mask) : col_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= SIZE_LOG2_RESET;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else
        begin
            size_reg    <= size_next;
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    `BMT_ASSERT(a_col_wrap, (cmd.rd_en && cmd.rd_last) |=> (col_cnt_reg == '0))
    `BMT_ASSERT(a_row_wrap, (cmd.wr_en && (row_sel == cnt_mask)) |=> (row_cnt_reg == '0))
    `BMT_ASSERT_NEVER(a_one_cmd, cmd.wr_en && cmd.rd_en)

endmodule
